FILE: hw/rtl/asps_pkg.sv
// shared types and constants of the approach setpoint step core
`timescale 1ns / 1ps
`default_nettype none
package asps_pkg;

  localparam int unsigned AXES     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MAG_W    = DATA_W + 1;
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned SPEED_W  = 21;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned NUM_W    = MAG_W + SPEED_W;
  localparam int unsigned LEN_W    = 34;
  localparam int unsigned Q_W      = SPEED_W;
  localparam int unsigned CFG_W    = RADIUS_W;

  typedef enum logic [0:0] {
    REG_SPEED  = 1'b0,
    REG_RADIUS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] cur;
    logic [AXES-1:0]             neg;
    logic [AXES-1:0][NUM_W-1:0]  num;
    logic                        reached;
  } sq_side_t;

  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] cur;
    logic [AXES-1:0]             neg;
    logic                        reached;
    logic                        zero;
  } div_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/asps_sqrt.sv
// pipelined integer square root, two radicand bits per stage
`timescale 1ns / 1ps
`default_nettype none
module asps_sqrt import asps_pkg::*; #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [SQ_W-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [LEN_W-1:0]       root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned STAGES = LEN_W;
  localparam int unsigned RAD_W  = 2 * LEN_W;
  localparam int unsigned REM_W  = LEN_W + 3;

  logic [RAD_W-1:0]  rad_q  [STAGES];
  logic [REM_W-1:0]  rem_q  [STAGES];
  logic [LEN_W-1:0]  root_q [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];
  logic              vld_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [RAD_W-1:0]  p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [LEN_W-1:0]  p_root;
    logic [SIDE_W-1:0] p_side;
    logic              p_vld;
    logic [REM_W-1:0]  rem_sh, trial, rem_d;
    logic [LEN_W-1:0]  root_d;

    if (k == 0) begin : g_first
      assign p_rad  = {{(RAD_W-SQ_W){1'b0}}, rad_i};
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = side_i;
      assign p_vld  = vld_i;
    end else begin : g_next
      assign p_rad  = rad_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_side = side_q[k-1];
      assign p_vld  = vld_q[k-1];
    end

    always_comb begin
      rem_sh = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
      trial  = {{(REM_W-LEN_W-2){1'b0}}, p_root, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {p_root[LEN_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {p_root[LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= p_rad << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign root_o = root_q[STAGES-1];
  assign side_o = side_q[STAGES-1];

  // final remainder never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> rem_q[STAGES-1] <= {{(REM_W-LEN_W-1){1'b0}}, root_o, 1'b0})
    else $error("sqrt remainder out of range");

endmodule
`default_nettype wire

FILE: hw/rtl/asps_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes
`timescale 1ns / 1ps
`default_nettype none
module asps_div import asps_pkg::*; #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [AXES-1:0][NUM_W-1:0]  num_i,
  input  wire logic [LEN_W-1:0]            den_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             vld_o,
  output logic [AXES-1:0][Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned STAGES = Q_W;
  localparam int unsigned HI_W   = NUM_W - Q_W;

  logic [AXES-1:0][LEN_W-1:0] rem_q  [STAGES];
  logic [AXES-1:0][Q_W-1:0]   low_q  [STAGES];
  logic [AXES-1:0][Q_W-1:0]   quo_q  [STAGES];
  logic [LEN_W-1:0]           den_q  [STAGES];
  logic [SIDE_W-1:0]          side_q [STAGES];
  logic                       vld_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [AXES-1:0][LEN_W-1:0] p_rem, rem_d;
    logic [AXES-1:0][Q_W-1:0]   p_low, p_quo, quo_d;
    logic [LEN_W-1:0]           p_den;
    logic [SIDE_W-1:0]          p_side;
    logic                       p_vld;

    if (k == 0) begin : g_first
      for (genvar a = 0; a < AXES; a++) begin : g_ln
        assign p_rem[a] = {{(LEN_W-HI_W){1'b0}}, num_i[a][NUM_W-1:Q_W]};
        assign p_low[a] = num_i[a][Q_W-1:0];
      end
      assign p_quo  = '0;
      assign p_den  = den_i;
      assign p_side = side_i;
      assign p_vld  = vld_i;
    end else begin : g_next
      assign p_rem  = rem_q[k-1];
      assign p_low  = low_q[k-1];
      assign p_quo  = quo_q[k-1];
      assign p_den  = den_q[k-1];
      assign p_side = side_q[k-1];
      assign p_vld  = vld_q[k-1];
    end

    always_comb begin
      logic [LEN_W:0] sh;
      for (int a = 0; a < AXES; a++) begin
        sh = {p_rem[a], p_low[a][Q_W-1]};
        if (sh >= {1'b0, p_den}) begin
          sh       = sh - {1'b0, p_den};
          quo_d[a] = {p_quo[a][Q_W-2:0], 1'b1};
        end else begin
          quo_d[a] = {p_quo[a][Q_W-2:0], 1'b0};
        end
        rem_d[a] = sh[LEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int a = 0; a < AXES; a++) begin
          low_q[k][a] <= p_low[a] << 1;
        end
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= p_den;
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign quo_o  = quo_q[STAGES-1];
  assign side_o = side_q[STAGES-1];

  // remainders stay below a nonzero divisor
  a_rem_lt_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && den_q[STAGES-1] != '0) |->
      (rem_q[STAGES-1][0] < den_q[STAGES-1] && rem_q[STAGES-1][1] < den_q[STAGES-1] &&
       rem_q[STAGES-1][2] < den_q[STAGES-1]))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: hw/rtl/approach_setpoint_step_core.sv
// top level of the approach setpoint step core
`timescale 1ns / 1ps
`default_nettype none
// Steps a position setpoint toward a target at the configured speed. Each input item carries
// the current and target positions (signed Q16.16); the result gives the next setpoint,
// saturated to the 32-bit range, and a reached flag (distance at or below reach_radius). One
// item is accepted every cycle. It passes the difference, square and sum registers, 34
// square-root stages (two radicand bits each), 21 divider stages (one quotient bit each) and
// the add and saturate register. The whole pipeline stalls only while the output register
// holds an item that is not taken. The user must write configuration while idle (unchecked).
module approach_setpoint_step_core import asps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z
  input  wire logic [191:0]       s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // next_x, next_y, next_z, reached, zero fill
  output logic [103:0]            m_axis_tdata_o
);

  localparam logic [SPEED_W-1:0]  SPEED_RST  = SPEED_W'(1) << FRAC_BITS;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1) << (FRAC_BITS - 1);

  logic [SPEED_W-1:0]  speed_q;
  logic [RADIUS_W-1:0] radius_q;
  logic                en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RST;
      radius_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPEED:  speed_q  <= cfg_wdata_i[SPEED_W-1:0];
        REG_RADIUS: radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: differences
  logic                        s1_vld_q;
  logic [AXES-1:0][DATA_W-1:0] s1_cur_q;
  logic [AXES-1:0]             s1_neg_q;
  logic [AXES-1:0][MAG_W-1:0]  s1_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    logic signed [MAG_W-1:0] d;
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        d = MAG_W'($signed(s_axis_tdata_i[96 + 32*a +: 32]))
          - MAG_W'($signed(s_axis_tdata_i[32*a +: 32]));
        s1_cur_q[a] <= s_axis_tdata_i[32*a +: 32];
        s1_neg_q[a] <= d[MAG_W-1];
        s1_mag_q[a] <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
    end
  end

  // stage 2: squares, scaled magnitudes, radius squared
  logic                        s2_vld_q;
  logic [AXES-1:0][DATA_W-1:0] s2_cur_q;
  logic [AXES-1:0]             s2_neg_q;
  logic [AXES-1:0][SQ_W-1:0]   s2_sq_q;
  logic [AXES-1:0][NUM_W-1:0]  s2_num_q;
  logic [2*RADIUS_W-1:0]       s2_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        s2_sq_q[a]  <= SQ_W'(s1_mag_q[a]) * SQ_W'(s1_mag_q[a]);
        s2_num_q[a] <= NUM_W'(s1_mag_q[a]) * NUM_W'(speed_q);
      end
      s2_cur_q <= s1_cur_q;
      s2_neg_q <= s1_neg_q;
      s2_r2_q  <= (2*RADIUS_W)'(radius_q) * (2*RADIUS_W)'(radius_q);
    end
  end

  // stage 3: sum of squares and reach test
  logic              s3_vld_q;
  logic [SQ_W-1:0]   s3_sum_q;
  sq_side_t          s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    logic [SQ_W-1:0] sum;
    if (en) begin
      sum = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_sum_q          <= sum;
      s3_side_q.cur     <= s2_cur_q;
      s3_side_q.neg     <= s2_neg_q;
      s3_side_q.num     <= s2_num_q;
      s3_side_q.reached <= sum <= SQ_W'(s2_r2_q);
    end
  end

  // square root
  logic             sq_vld;
  logic [LEN_W-1:0] sq_root;
  sq_side_t         sq_side;

  asps_sqrt #(
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_sum_q),
    .side_i (s3_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // division by the length
  div_side_t                dv_side_in;
  div_side_t                dv_side;
  logic                     dv_vld;
  logic [AXES-1:0][Q_W-1:0] dv_quo;

  always_comb begin
    dv_side_in.cur     = sq_side.cur;
    dv_side_in.neg     = sq_side.neg;
    dv_side_in.reached = sq_side.reached;
    dv_side_in.zero    = sq_root == '0;
  end

  asps_div #(
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .num_i  (sq_side.num),
    .den_i  (sq_root),
    .side_i (dv_side_in),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // output stage: signed step and saturating add
  logic                        out_vld_q;
  logic [AXES-1:0][DATA_W-1:0] out_next_q;
  logic                        out_reached_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    logic [DATA_W+1:0] stepm, step, sum;
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        stepm = (DATA_W+2)'(dv_quo[a]);
        step  = dv_side.neg[a] ? -stepm : stepm;
        sum   = {{2{dv_side.cur[a][DATA_W-1]}}, dv_side.cur[a]} + step;
        if (dv_side.zero) begin
          out_next_q[a] <= dv_side.cur[a];
        end else if (sum[DATA_W+1:DATA_W-1] != 3'b000 &&
                     sum[DATA_W+1:DATA_W-1] != 3'b111) begin
          out_next_q[a] <= sum[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          out_next_q[a] <= sum[DATA_W-1:0];
        end
      end
      out_reached_q <= dv_side.reached;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_reached_q, out_next_q};

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_zero_len_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && dv_side.zero) |-> dv_side.reached)
    else $error("zero distance without reached flag");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_vld_q) && $stable(s3_vld_q)))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

FILE: tb/tb_approach_setpoint_step_core.sv
// testbench of the approach setpoint step core: directed table, random items, back-pressure
`timescale 1ns / 1ps
module tb_approach_setpoint_step_core;
  import asps_pkg::*;

  localparam int unsigned LATENCY     = 59;
  localparam int unsigned N_RANDOM    = 500;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned N_DIRECTED  = 16;

  typedef struct packed {
    logic signed [31:0] tz, ty, tx, cz, cy, cx;
  } sample_t;

  typedef struct packed {
    logic               reached;
    logic signed [31:0] nz, ny, nx;
  } setpoint_t;

  typedef struct {
    sample_t   s;
    logic      has_fixed;
    setpoint_t fixed;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [191:0]       s_axis_tdata_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [103:0]       m_axis_tdata_o;

  approach_setpoint_step_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  logic [SPEED_W-1:0]  speed_q;
  logic [RADIUS_W-1:0] radius_q;

  setpoint_t pending_setpoints[$];
  int unsigned n_errors, n_sent, n_got, n_reached, n_zero_dist, idle_cycles;
  bit          hold_off, sink_on;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // floor of the square root of a 66-bit sum
  function automatic logic [LEN_W-1:0] root_floor(logic [67:0] v);
    logic [LEN_W-1:0] r, c;
    r = '0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      c = r | (LEN_W'(1) << b);
      if ({34'd0, c} * {34'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic setpoint_t next_setpoint(sample_t s);
    setpoint_t        o;
    logic signed [32:0] d[3];
    logic signed [31:0] c[3];
    logic [32:0]      m[3];
    logic [67:0]      sum;
    logic [LEN_W-1:0] len;
    logic [63:0]      q;
    logic signed [34:0] n;
    logic signed [31:0] res[3];
    c = '{s.cx, s.cy, s.cz};
    d[0] = 33'(s.tx) - 33'(s.cx);
    d[1] = 33'(s.ty) - 33'(s.cy);
    d[2] = 33'(s.tz) - 33'(s.cz);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sum += {35'd0, m[i]} * {35'd0, m[i]};
    end
    o.reached = sum <= {37'd0, radius_q} * {37'd0, radius_q};
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      res[i] = c[i];
      if (len != 0) begin
        q = ({31'd0, m[i]} * {43'd0, speed_q}) / {30'd0, len};
        n = d[i] < 0 ? 35'(c[i]) - 35'(q) : 35'(c[i]) + 35'(q);
        if (n > 35'sh7FFFFFFF) res[i] = 32'sh7FFFFFFF;
        else if (n < -35'sh80000000) res[i] = 32'sh80000000;
        else res[i] = n[31:0];
      end
    end
    o.nx = res[0];
    o.ny = res[1];
    o.nz = res[2];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d expected %0d", what, n_got, got, want);
    n_errors++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SPEED) speed_q = val[SPEED_W-1:0];
    else radius_q = val[RADIUS_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_setpoints.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_sample(sample_t s, bit gaps);
    setpoint_t   e;
    int unsigned gap;
    gap = 0;
    if (gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    e = next_setpoint(s);
    pending_setpoints = {pending_setpoints, e};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_sent++;
    if (s.cx == s.tx && s.cy == s.ty && s.cz == s.tz) n_zero_dist++;
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 70000)
                                      : 32'h80000000 + $urandom_range(0, 70000);
      2: return base;
      3: return base + $urandom_range(0, 8) - 4;
      default: return base + $signed(32'($urandom_range(0, 2000000))) - 1000000;
    endcase
  endfunction

  // output side: random stalls, checks each result against the oldest expectation
  always @(posedge clk_i) begin
    setpoint_t g, e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      g = m_axis_tdata_o[96:0];
      if (pending_setpoints.size() == 0) begin
        $display("unexpected result item %0d", n_got);
        n_errors++;
      end else begin
        e = pending_setpoints.pop_front();
        if (g.nx !== e.nx) report_mismatch("next_x", g.nx, e.nx);
        if (g.ny !== e.ny) report_mismatch("next_y", g.ny, e.ny);
        if (g.nz !== e.nz) report_mismatch("next_z", g.nz, e.nz);
        if (g.reached !== e.reached) report_mismatch("reached", g.reached, e.reached);
        if (e.reached) n_reached++;
      end
      n_got++;
    end
  end

  int unsigned sink_wait;
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      m_axis_tready_i <= 1'b0;
      sink_wait <= 0;
    end else if (!sink_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (sink_wait != 0) begin
      m_axis_tready_i <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      sink_wait <= $urandom_range(0, 13);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_setpoints.size());
      $display("Mismatches found");
      $finish;
    end
  end

  row_t directed[N_DIRECTED];
  initial begin
    sample_t s;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SPEED;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    hold_off = 1'b0;
    sink_on = 1'b0;
    idle_cycles = 0;
    speed_q = SPEED_W'(1 << 16);
    radius_q = RADIUS_W'(1 << 15);

    directed[0]  = '{'{0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0}};
    directed[1]  = '{'{0, 0, 32'sh00030000, 0, 0, 0}, 1, '{0, 0, 0, 32'sh10000}};
    directed[2]  = '{'{0, 32'shFFFE0000, 0, 0, 0, 0}, 1, '{0, 0, -32'sh10000, 0}};
    directed[3]  = '{'{32'sh4000, 0, 0, 0, 0, 0}, 0, '0};
    directed[4]  = '{'{32'sh8000, 0, 0, 0, 0, 0}, 1, '{1, 32'sh10000, 0, 0}};
    directed[5]  = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                       32'sh80000000, 32'sh80000000}, 0, '0};
    directed[6]  = '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '0};
    directed[7]  = '{'{0, 0, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF}, 1,
                     '{1, 0, 0, 32'sh7FFFFFFF}};
    directed[8]  = '{'{0, 0, 32'sh7FFFFFFF, 0, 0, 32'sh7FFF8000}, 1,
                     '{1, 0, 0, 32'sh7FFFFFFF}};
    directed[9]  = '{'{0, 32'sh80000000, 0, 0, 32'sh80008000, 0}, 1,
                     '{1, 0, 32'sh80000000, 0}};
    directed[10] = '{'{32'sh12345, 32'sh2345, 32'sh345, 32'sh1, 32'sh2, 32'sh3}, 0, '0};
    directed[11] = '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0}, 0, '0};
    directed[12] = '{'{32'h55555555, 32'hAAAAAAAA, 32'h33333333, 32'hCCCCCCCC,
                       32'h0F0F0F0F, 32'hF0F0F0F0}, 0, '0};
    directed[13] = '{'{1, 0, 0, 0, 0, 0}, 0, '0};
    directed[14] = '{'{32'sh70000000, 0, 0, 32'sh7FFFFF00, 0, 0}, 0, '0};
    directed[15] = '{'{32'sh80000000, 0, 0, 32'sh80000001, 0, 0}, 0, '0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers, no gaps
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(directed[i].s, 0);
      if (directed[i].has_fixed) pending_setpoints[$] = directed[i].fixed;
    end
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    // extremes of both registers, then random settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_SPEED, 0); write_reg(REG_RADIUS, 0); end
        1: begin write_reg(REG_SPEED, 21'h100000); write_reg(REG_RADIUS, 31'h7FFFFFFF); end
        2: begin write_reg(REG_SPEED, 21'h1FFFFF); write_reg(REG_RADIUS, 1); end
        default: begin
          write_reg(REG_SPEED, $urandom_range(0, 21'h1FFFFF));
          write_reg(REG_RADIUS, $urandom() & 32'h7FFFFFFF);
          if ($urandom_range(0, 1)) write_reg(REG_RADIUS, $urandom_range(0, 32'h40000));
        end
      endcase
      sink_on = (ph != 1);
      for (int i = 0; i < (ph < 3 ? 6 : 0); i++) send_sample(directed[i * 2 + 1].s, ph == 2);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        logic [31:0] bx, by, bz;
        bx = $urandom(); by = $urandom(); bz = $urandom();
        if ($urandom_range(0, 3) == 0) begin
          bx = $urandom_range(0, 255); by = 0; bz = 0;
        end
        s = {rand_coord(bz), rand_coord(by), rand_coord(bx), bz, by, bx};
        // stretches with no idling on the input side
        send_sample(s, (i / 20) % 3 != 0);
        if (ph == 4 && i == 30) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
      end
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
    end

    $display("%0d items sent, %0d results checked, %0d reached, %0d with zero distance",
             n_sent, n_got, n_reached, n_zero_dist);
    $display("register settings covered zero, maximum and random speed and radius");
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
